[rtl/wcs_pkg.sv]
// Package: types, constants and register reset values for the winding current block
package wcs_pkg;

    localparam int NUM_POINTS = 7;
    localparam int REG_COUNT  = 7;
    localparam int USED       = (NUM_POINTS < REG_COUNT) ? NUM_POINTS : REG_COUNT;
    localparam int IDX_W      = 3;
    localparam int SEG_W      = 3;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;
    localparam int DIV_STEPS  = 16;

    localparam logic [31:0] POINT_RESET [REG_COUNT] = '{
        32'd0, 32'd19660800, 32'd39322068, 32'd65537695,
        32'd111414473, 32'd288364128, 32'd444999142
    };

    typedef struct packed {
        logic signed [15:0] motor_speed;
        logic [15:0]        gain_scale;
        logic [15:0]        retract_gain;
    } in_item_t;

    typedef struct packed {
        logic signed [16:0] current_target;
        logic               clipped;
    } out_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [31:0]      data;
    } cfg_beat_t;

    // classified item: either a fixed current or a segment to interpolate
    typedef struct packed {
        logic        interp;
        logic        pos;
        logic        dn;
        logic [15:0] c0;
        logic [15:0] dc;
        logic [15:0] dx;
        logic [15:0] d;
        logic [15:0] scale;
        logic [15:0] retract;
    } job_t;

endpackage

[rtl/wcs_front.sv]
// Front part: speed magnitude, segment search and item classification
module wcs_front
    import wcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  cfg_beat_t   cfg_beat,
    input  logic        take,
    input  in_item_t    item,
    output job_t        job
);
    logic [31:0] points_reg [REG_COUNT];
    logic [16:0] n;
    logic        neg;
    logic [15:0] sp [REG_COUNT];
    logic [15:0] cu [REG_COUNT];
    logic [SEG_W-1:0] k;
    logic        found;
    logic [16:0] s0;
    logic [15:0] c0;
    logic [15:0] c1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                points_reg[i] <= POINT_RESET[i];
            end
        end
        else if (cfg_valid && (32'(cfg_beat.index) < REG_COUNT))
        begin
            points_reg[cfg_beat.index] <= cfg_beat.data;
        end
    end

    always_comb
    begin
        for (int i = 0; i < REG_COUNT; i++)
        begin
            sp[i] = points_reg[i][31:16];
            cu[i] = points_reg[i][15:0];
        end
        neg = item.motor_speed[15];
        n   = neg ? (17'h10000 - {1'b0, item.motor_speed}) : {1'b0, item.motor_speed};
        k     = SEG_W'(USED - 1);
        found = 1'b0;
        for (int i = 1; i < USED; i++)
        begin
            if (!found && (n < {1'b0, sp[i]}))
            begin
                k     = SEG_W'(i);
                found = 1'b1;
            end
        end
        s0 = {1'b0, sp[k - 1'b1]};
        c0 = cu[k - 1'b1];
        c1 = cu[k];
        job.pos     = !neg && (item.motor_speed != 16'sd0);
        job.scale   = item.gain_scale;
        job.retract = item.retract_gain;
        job.interp  = 1'b0;
        job.dn      = 1'b0;
        job.c0      = c0;
        job.dc      = 16'd0;
        job.dx      = 16'd0;
        job.d       = 16'd1;
        if (n >= {1'b0, sp[USED-1]})
        begin
            job.c0 = cu[USED-1];
        end
        else if (n <= {1'b0, sp[0]})
        begin
            job.c0 = cu[0];
        end
        else if (!found)
        begin
            job.c0 = cu[USED-1];
        end
        else if (n > s0)
        begin
            job.interp = 1'b1;
            job.dn     = c1 < c0;
            job.dc     = (c1 < c0) ? (c0 - c1) : (c1 - c0);
            job.dx     = 16'(n - s0);
            job.d      = sp[k] - 16'(s0);
        end
    end

    logic unused;
    assign unused = take;
endmodule

[rtl/wcs_queue.sv]
// Short queue between front and back parts
module wcs_queue
    import wcs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_data,
    output job_t head,
    output logic pop_valid
);
    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg;
    logic [QPTR_W-1:0] rd_reg;
    logic [QPTR_W:0]   cnt_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop_valid)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (push ? 1'b1 : 1'b0) - (pop_valid ? 1'b1 : 1'b0);
        end
    end

    assign pop_valid = cnt_reg != '0;
    assign head      = mem_reg[rd_reg];
endmodule

[rtl/wcs_back.sv]
// Back part: pipelined rounding divider, gain multipliers, saturation
module wcs_back
    import wcs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  job_t      job,
    output logic      out_valid,
    output out_item_t out_item
);
    typedef struct packed {
        logic        pos;
        logic        interp;
        logic        dn;
        logic [15:0] c0;
        logic [15:0] d;
        logic [15:0] scale;
        logic [15:0] retract;
        logic [32:0] rem;
        logic [31:0] quo;
    } dstage_t;

    logic    v_reg [DIV_STEPS+1];
    dstage_t s_reg [DIV_STEPS+1];
    dstage_t s_next [DIV_STEPS];

    // numerator (dc*dx + d/2); quotient below 2^16, so 16 restoring steps
    always_ff @(posedge clk)
    begin
        s_reg[0].pos     <= job.pos;
        s_reg[0].interp  <= job.interp;
        s_reg[0].dn      <= job.dn;
        s_reg[0].c0      <= job.c0;
        s_reg[0].d       <= job.d;
        s_reg[0].scale   <= job.scale;
        s_reg[0].retract <= job.retract;
        s_reg[0].rem     <= '0;
        s_reg[0].quo     <= job.dc * job.dx + 32'(job.d >> 1);
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            s_reg[i+1] <= s_next[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            s_next[i] = s_reg[i];
            if (i == 0)
            begin
                s_next[i].rem = {17'd0, s_reg[i].quo[31:16]};
                s_next[i].quo = {s_reg[i].quo[15:0], 16'd0};
            end
            s_next[i].rem = {s_next[i].rem[31:0], s_next[i].quo[31]};
            s_next[i].quo = {s_next[i].quo[30:0], 1'b0};
            if (s_next[i].rem >= {17'd0, s_reg[i].d})
            begin
                s_next[i].rem    = s_next[i].rem - {17'd0, s_reg[i].d};
                s_next[i].quo[0] = 1'b1;
            end
        end
    end

    logic [15:0] q;
    logic [15:0] cur_next;
    logic [15:0] cur_reg;
    logic        p1_pos_reg;
    logic [15:0] p1_ret_reg;
    logic [31:0] p1_reg;
    logic        p2_pos_reg;
    logic [47:0] p2_reg;
    logic [15:0] p1_sc_reg;
    logic [15:0] sc_reg;
    logic        cpos_reg;
    logic [15:0] cret_reg;
    logic        v1_reg;
    logic        v2_reg;
    logic        v3_reg;
    logic        v4_reg;
    logic [47:0] pr;
    logic [33:0] mag;
    logic [20:0] magn;
    out_item_t   res_next;
    out_item_t   res_reg;

    assign q = s_reg[DIV_STEPS].quo[15:0];
    always_comb
    begin
        cur_next = s_reg[DIV_STEPS].c0;
        if (s_reg[DIV_STEPS].interp)
        begin
            cur_next = s_reg[DIV_STEPS].dn ? (s_reg[DIV_STEPS].c0 - q)
                                           : (s_reg[DIV_STEPS].c0 + q);
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        sc_reg     <= s_reg[DIV_STEPS].scale;
        cret_reg   <= s_reg[DIV_STEPS].retract;
        cpos_reg   <= s_reg[DIV_STEPS].pos;
        p1_reg     <= cur_reg * sc_reg;
        p1_ret_reg <= cret_reg;
        p1_pos_reg <= cpos_reg;
        p1_sc_reg  <= sc_reg;
        p2_reg     <= p1_pos_reg ? (48'(p1_reg) * 48'(p1_ret_reg)) : 48'(p1_reg);
        p2_pos_reg <= p1_pos_reg;
        res_reg    <= res_next;
    end

    always_comb
    begin
        pr = p2_reg;
        res_next = '0;
        if (p2_pos_reg)
        begin
            mag  = 34'((pr + 48'h800_0000) >> 28);
            magn = 21'(mag);
            if (mag > 34'd65536)
            begin
                res_next.clipped        = 1'b1;
                res_next.current_target = -17'sd65536;
            end
            else
            begin
                res_next.current_target = 17'(21'h20000 - magn);
            end
        end
        else
        begin
            mag  = 34'((pr + 48'h2000) >> 14);
            magn = 21'(mag);
            if (mag > 34'd65535)
            begin
                res_next.clipped        = 1'b1;
                res_next.current_target = 17'sd65535;
            end
            else
            begin
                res_next.current_target = 17'(magn);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= DIV_STEPS; i++)
            begin
                v_reg[i] <= 1'b0;
            end
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int i = 0; i < DIV_STEPS; i++)
            begin
                v_reg[i+1] <= v_reg[i];
            end
            v1_reg <= v_reg[DIV_STEPS];
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    logic unused;
    assign unused  = ^p1_sc_reg;
    assign out_valid = v4_reg;
    assign out_item  = res_reg;
endmodule

[rtl/winding_current_from_speed.sv]
// Top level: winding current target from motor speed
// channel  | handshake              | payload
// item in  | start, busy            | item (in_item_t)
// config   | cfg_valid, cfg_ready   | cfg_index, cfg_data
// result   | done (one-cycle beat)  | result (out_item_t)
// One item per cycle; each start beat yields one done beat.
// Path: queue write at the start edge, 17 divider pipeline registers, the
// current register, two gain multiplier stages and the output register.
// busy stays low; config is always ready.
// Reset loads the breakpoint defaults and empties every stage at once.
module winding_current_from_speed
    import wcs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  in_item_t         item,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [31:0]      cfg_data,
    output logic             done,
    output out_item_t        result
);
    job_t      job;
    job_t      head;
    logic      take;
    logic      qv;
    cfg_beat_t cb;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign take      = start && !busy;
    assign cb.index  = cfg_index;
    assign cb.data   = cfg_data;

    wcs_front u_front (
        .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid && cfg_ready),
        .cfg_beat(cb), .take(take), .item(item), .job(job)
    );

    wcs_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(take), .push_data(job),
        .head(head), .pop_valid(qv)
    );

    wcs_back u_back (
        .clk(clk), .rst_n(rst_n), .in_valid(qv), .job(head),
        .out_valid(done), .out_item(result)
    );

`ifndef SYNTHESIS
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");
    a_clip_pos: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.clipped |-> result.current_target == 17'sd65535
            || result.current_target == -17'sd65536)
        else $error("clip value wrong");
    a_queue_drain: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> qv)
        else $error("queue lost beat");
`endif
endmodule
